FILE: rtl/nsf_pkg.sv
package nsf_pkg;

  localparam int PAYLOAD_MAX = 80;
  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int TYPE_LEN = 5;
  localparam int NUM_TYPES = 8;

  localparam logic [CNT_W-1:0] PAYLOAD_MAX_C = CNT_W'(PAYLOAD_MAX);
  localparam logic [CNT_W-1:0] TYPE_LEN_C = CNT_W'(TYPE_LEN);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_DATA,
    PH_CS0,
    PH_CS1,
    PH_CR,
    PH_LF
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_END,
    KIND_ABORT
  } kind_e;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  sentence_type;
    logic [6:0]  payload_length;
  } result_t;

  localparam logic [8*TYPE_LEN-1:0] KNOWN_TYPES [NUM_TYPES] = '{
    "GPGLL", "GNGLL", "GLGSB", "GPGSV", "GNGSA", "GNGGA", "GNVTG", "GNRMC"
  };

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch inside {[8'h30:8'h39]}) begin
      d = ch - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (ch inside {[8'h41:8'h46]}) begin
      d = ch - 8'h37;
      return {1'b1, d[3:0]};
    end
    if (ch inside {[8'h61:8'h66]}) begin
      d = ch - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  function automatic logic [3:0] match_type(input logic [8*TYPE_LEN-1:0] chars);
    logic [3:0] code;
    code = 4'd0;
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      if (chars == KNOWN_TYPES[t]) code = 4'(t + 1);
    end
    return code;
  endfunction

  function automatic logic [6:0] len_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+6:0] wide;
    wide = {7'd0, cnt};
    return wide[6:0];
  endfunction

endpackage

FILE: rtl/nsf_in_if.sv
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/nsf_out_if.sv
interface nsf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic [3:0] sentence_type;
  logic [6:0] payload_length;

  modport source (
    output valid, output result_kind, output payload_byte,
    output sentence_type, output payload_length, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte,
    input sentence_type, input payload_length, output ready
  );
endinterface

FILE: rtl/nsf_in_stage.sv
module nsf_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsf_in_if.sink     in_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       take;

  assign in_i.ready = !valid_q || advance_i;
  assign take = in_i.valid && in_i.ready;
  assign valid_o = valid_q;
  assign byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.rx_byte;
    end
  end

endmodule

FILE: rtl/nsf_core.sv
module nsf_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             emit_o,
  output nsf_pkg::result_t res_o
);

  nsf_pkg::phase_e               phase_q, phase_d;
  logic [7:0]                    chars_q [nsf_pkg::TYPE_LEN];
  logic [nsf_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [7:0]                    xor_q, xor_d;
  logic [3:0]                    type_q, type_d;
  logic                          open_q, open_d;
  logic                          wr_char;
  logic [4:0]                    hex;
  logic [8*nsf_pkg::TYPE_LEN-1:0] chars_flat;

  always_comb begin
    for (int i = 0; i < nsf_pkg::TYPE_LEN; i++) begin
      chars_flat[8*(nsf_pkg::TYPE_LEN-1-i) +: 8] = chars_q[i];
    end
  end

  assign hex = nsf_pkg::hex_value(byte_i);

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d = cnt_q;
    xor_d = xor_q;
    type_d = type_q;
    open_d = open_q;
    wr_char = 1'b0;

    if (byte_i == nsf_pkg::CH_DOLLAR) begin
      open_d = 1'b0;
      phase_d = nsf_pkg::PH_TYPE;
      cnt_d = '0;
      xor_d = 8'h00;
    end else begin
      case (phase_q)
        nsf_pkg::PH_TYPE: begin
          if (byte_i == nsf_pkg::CH_COMMA) begin
            if (cnt_q == nsf_pkg::TYPE_LEN_C) begin
              type_d = nsf_pkg::match_type(chars_flat);
              xor_d = xor_q ^ byte_i;
              cnt_d = '0;
              phase_d = nsf_pkg::PH_DATA;
              open_d = 1'b1;
            end else begin
              phase_d = nsf_pkg::PH_IDLE;
            end
          end else if (cnt_q >= nsf_pkg::TYPE_LEN_C) begin
            phase_d = nsf_pkg::PH_IDLE;
          end else begin
            wr_char = 1'b1;
            cnt_d = cnt_q + 1'b1;
            xor_d = xor_q ^ byte_i;
          end
        end
        nsf_pkg::PH_DATA: begin
          if (byte_i == nsf_pkg::CH_STAR) begin
            phase_d = nsf_pkg::PH_CS0;
          end else if (cnt_q >= nsf_pkg::PAYLOAD_MAX_C) begin
            phase_d = nsf_pkg::PH_IDLE;
            open_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
            xor_d = xor_q ^ byte_i;
          end
        end
        nsf_pkg::PH_CS0: begin
          if (hex[4] && hex[3:0] == xor_q[7:4]) begin
            phase_d = nsf_pkg::PH_CS1;
          end else begin
            phase_d = nsf_pkg::PH_IDLE;
            open_d = 1'b0;
          end
        end
        nsf_pkg::PH_CS1: begin
          if (hex[4] && hex[3:0] == xor_q[3:0]) begin
            phase_d = nsf_pkg::PH_CR;
          end else begin
            phase_d = nsf_pkg::PH_IDLE;
            open_d = 1'b0;
          end
        end
        nsf_pkg::PH_CR: begin
          if (byte_i == nsf_pkg::CH_CR) begin
            phase_d = nsf_pkg::PH_LF;
          end else begin
            phase_d = nsf_pkg::PH_IDLE;
            open_d = 1'b0;
          end
        end
        nsf_pkg::PH_LF: begin
          phase_d = nsf_pkg::PH_IDLE;
          open_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    emit_o = 1'b0;
    res_o.result_kind = nsf_pkg::KIND_ABORT;
    res_o.payload_byte = 8'h00;
    res_o.sentence_type = type_q;
    res_o.payload_length = 7'd0;

    if (byte_i == nsf_pkg::CH_DOLLAR) begin
      emit_o = open_q;
    end else begin
      case (phase_q)
        nsf_pkg::PH_DATA: begin
          if (byte_i != nsf_pkg::CH_STAR) begin
            if (cnt_q >= nsf_pkg::PAYLOAD_MAX_C) begin
              emit_o = open_q;
            end else begin
              emit_o = 1'b1;
              res_o.result_kind = nsf_pkg::KIND_PAYLOAD;
              res_o.payload_byte = byte_i;
            end
          end
        end
        nsf_pkg::PH_CS0: begin
          if (!(hex[4] && hex[3:0] == xor_q[7:4])) begin
            emit_o = open_q;
          end
        end
        nsf_pkg::PH_CS1: begin
          if (!(hex[4] && hex[3:0] == xor_q[3:0])) begin
            emit_o = open_q;
          end
        end
        nsf_pkg::PH_CR: begin
          if (byte_i != nsf_pkg::CH_CR) begin
            emit_o = open_q;
          end
        end
        nsf_pkg::PH_LF: begin
          if (byte_i == nsf_pkg::CH_LF) begin
            emit_o = 1'b1;
            res_o.result_kind = nsf_pkg::KIND_END;
            res_o.payload_length = nsf_pkg::len_of(cnt_q);
          end else begin
            emit_o = open_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nsf_pkg::PH_IDLE;
      cnt_q <= '0;
      xor_q <= 8'h00;
      type_q <= 4'd0;
      open_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      xor_q <= xor_d;
      type_q <= type_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_char) begin
      chars_q[cnt_q[2:0]] <= byte_i;
    end
  end

  a_open_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (phase_q == nsf_pkg::PH_DATA || phase_q == nsf_pkg::PH_CS0 ||
                phase_q == nsf_pkg::PH_CS1 || phase_q == nsf_pkg::PH_CR ||
                phase_q == nsf_pkg::PH_LF))
    else $error("payload open outside payload phases");

  a_type_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == nsf_pkg::PH_TYPE |-> cnt_q <= nsf_pkg::TYPE_LEN_C)
    else $error("type field count overran");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= nsf_pkg::PAYLOAD_MAX_C)
    else $error("payload count overran");

  a_end_from_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && res_o.result_kind == nsf_pkg::KIND_END
      |-> phase_q == nsf_pkg::PH_LF && open_q)
    else $error("end marker outside terminator");

  a_closed_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && res_o.result_kind != nsf_pkg::KIND_PAYLOAD |=> !open_q)
    else $error("sentence still open after end or abort");

endmodule

FILE: rtl/nsf_out_stage.sv
module nsf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nsf_pkg::result_t res_i,
  output logic             space_o,
  nsf_out_if.source        out_o
);

  logic             valid_q;
  nsf_pkg::result_t res_q;

  assign space_o = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.result_kind = res_q.result_kind;
  assign out_o.payload_byte = res_q.payload_byte;
  assign out_o.sentence_type = res_q.sentence_type;
  assign out_o.payload_length = res_q.payload_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: rtl/nmea_sentence_framer.sv
// NMEA 0183 sentence framer. One received character is taken per beat on
// in_i and each beat can follow the previous one in the next cycle; a
// character is held in the input register, decoded combinationally, and
// its result, if any, is loaded into the output register once that register
// has space; throughput is one character per cycle while out_o is ready.
// A '$' always restarts framing. Each payload character up to PAYLOAD_MAX is
// forwarded as a payload beat, a sentence with a good checksum and CR LF
// ends with an end beat carrying type code and payload length, and a
// sentence cancelled after its type field ends with an abort beat. Bytes
// outside a sentence and a bad type field produce no beat at all.
module nmea_sentence_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsf_in_if.sink    in_i,
  nsf_out_if.source out_o
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             space;
  logic             advance;
  logic             emit;
  nsf_pkg::result_t res;

  assign advance = in_valid && space;

  nsf_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  nsf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte),
    .emit_o (emit),
    .res_o  (res)
  );

  nsf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && emit),
    .res_i   (res),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

FILE: dv/tb_nmea_sentence_framer.sv
`timescale 1ns / 100ps

module tb_nmea_sentence_framer;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_BEAT
  } check_e;

  typedef struct {
    logic [7:0]       ch;
    check_e           mode;
    nsf_pkg::result_t beat;
  } dir_row_t;

  localparam nsf_pkg::result_t NO_BEAT = '0;
  localparam int NUM_DIR = 24;
  localparam int NUM_STIM = NUM_DIR + 1250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nsf_in_if  in_if ();
  nsf_out_if out_if ();

  nmea_sentence_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // framer state as seen by the predictor
  nsf_pkg::phase_e fr_phase = nsf_pkg::PH_IDLE;
  logic [7:0]      fr_chars [nsf_pkg::TYPE_LEN] = '{default: 8'h00};
  int              fr_count = 0;
  logic [7:0]      fr_xor = 8'h00;
  logic [3:0]      fr_type = 4'd0;
  bit              fr_open = 1'b0;

  logic [7:0]       stim_bytes [$];
  check_e           stim_mode [$];
  nsf_pkg::result_t stim_beat [$];
  nsf_pkg::result_t pending_beats [$];

  int n_accepted = 0;
  int n_errors = 0;
  int n_payload = 0;
  int n_closed = 0;
  int n_aborted = 0;

  logic [15:0] rdy_pat = 16'hffff;
  int          rdy_left = 0;

  nsf_pkg::result_t got_beat;
  nsf_pkg::result_t want_beat;
  nsf_pkg::result_t next_beat;
  bit               next_hit;

  dir_row_t dir_tab [NUM_DIR] = '{
    '{8'h00,              CHK_NONE,  NO_BEAT},
    '{8'hff,              CHK_NONE,  NO_BEAT},
    '{nsf_pkg::CH_DOLLAR, CHK_NONE,  NO_BEAT},
    '{"G",                CHK_MODEL, NO_BEAT},
    '{"P",                CHK_MODEL, NO_BEAT},
    '{"G",                CHK_MODEL, NO_BEAT},
    '{"L",                CHK_MODEL, NO_BEAT},
    '{"L",                CHK_MODEL, NO_BEAT},
    '{nsf_pkg::CH_COMMA,  CHK_MODEL, NO_BEAT},
    '{"A",                CHK_BEAT,  '{nsf_pkg::KIND_PAYLOAD, 8'h41, 4'd1, 7'd0}},
    '{nsf_pkg::CH_STAR,   CHK_MODEL, NO_BEAT},
    '{"3",                CHK_MODEL, NO_BEAT},
    '{"d",                CHK_MODEL, NO_BEAT},
    '{nsf_pkg::CH_CR,     CHK_MODEL, NO_BEAT},
    '{nsf_pkg::CH_LF,     CHK_BEAT,  '{nsf_pkg::KIND_END, 8'h00, 4'd1, 7'd1}},
    '{nsf_pkg::CH_DOLLAR, CHK_MODEL, NO_BEAT},
    '{"G",                CHK_MODEL, NO_BEAT},
    '{"N",                CHK_MODEL, NO_BEAT},
    '{"R",                CHK_MODEL, NO_BEAT},
    '{"M",                CHK_MODEL, NO_BEAT},
    '{"C",                CHK_MODEL, NO_BEAT},
    '{nsf_pkg::CH_COMMA,  CHK_MODEL, NO_BEAT},
    '{nsf_pkg::CH_CR,     CHK_BEAT,  '{nsf_pkg::KIND_PAYLOAD, 8'h0d, 4'd8, 7'd0}},
    '{nsf_pkg::CH_DOLLAR, CHK_BEAT,  '{nsf_pkg::KIND_ABORT, 8'h00, 4'd8, 7'd0}}
  };

  // -1 for anything that is not a hex digit
  function automatic int nib_val(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
    if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [3:0] type_code_of();
    logic [8*nsf_pkg::TYPE_LEN-1:0] word;
    word = {fr_chars[0], fr_chars[1], fr_chars[2], fr_chars[3], fr_chars[4]};
    for (int t = 0; t < nsf_pkg::NUM_TYPES; t++) begin
      if (word == nsf_pkg::KNOWN_TYPES[t]) return 4'(t + 1);
    end
    return 4'd0;
  endfunction

  function automatic bit close_sentence(output nsf_pkg::result_t beat);
    bit was_open;
    was_open = fr_open;
    beat = '{nsf_pkg::KIND_ABORT, 8'h00, fr_type, 7'd0};
    fr_phase = nsf_pkg::PH_IDLE;
    fr_open = 1'b0;
    return was_open;
  endfunction

  function automatic bit frame_char(input logic [7:0] ch, output nsf_pkg::result_t beat);
    bit hit;
    hit = 1'b0;
    beat = NO_BEAT;
    if (ch == nsf_pkg::CH_DOLLAR) begin
      hit = close_sentence(beat);
      fr_phase = nsf_pkg::PH_TYPE;
      fr_count = 0;
      fr_xor = 8'h00;
    end else begin
      case (fr_phase)
        nsf_pkg::PH_TYPE: begin
          if (ch == nsf_pkg::CH_COMMA) begin
            if (fr_count == nsf_pkg::TYPE_LEN) begin
              fr_type = type_code_of();
              fr_xor ^= ch;
              fr_count = 0;
              fr_phase = nsf_pkg::PH_DATA;
              fr_open = 1'b1;
            end else begin
              hit = close_sentence(beat);
            end
          end else if (fr_count >= nsf_pkg::TYPE_LEN) begin
            hit = close_sentence(beat);
          end else begin
            fr_chars[fr_count] = ch;
            fr_count++;
            fr_xor ^= ch;
          end
        end
        nsf_pkg::PH_DATA: begin
          if (ch == nsf_pkg::CH_STAR) begin
            fr_phase = nsf_pkg::PH_CS0;
          end else if (fr_count >= nsf_pkg::PAYLOAD_MAX) begin
            hit = close_sentence(beat);
          end else begin
            fr_count++;
            fr_xor ^= ch;
            hit = 1'b1;
            beat = '{nsf_pkg::KIND_PAYLOAD, ch, fr_type, 7'd0};
          end
        end
        nsf_pkg::PH_CS0: begin
          if (nib_val(ch) != int'(fr_xor[7:4])) hit = close_sentence(beat);
          else fr_phase = nsf_pkg::PH_CS1;
        end
        nsf_pkg::PH_CS1: begin
          if (nib_val(ch) != int'(fr_xor[3:0])) hit = close_sentence(beat);
          else fr_phase = nsf_pkg::PH_CR;
        end
        nsf_pkg::PH_CR: begin
          if (ch != nsf_pkg::CH_CR) hit = close_sentence(beat);
          else fr_phase = nsf_pkg::PH_LF;
        end
        nsf_pkg::PH_LF: begin
          if (ch != nsf_pkg::CH_LF) begin
            hit = close_sentence(beat);
          end else begin
            fr_phase = nsf_pkg::PH_IDLE;
            fr_open = 1'b0;
            hit = 1'b1;
            beat = '{nsf_pkg::KIND_END, 8'h00, fr_type, 7'(fr_count)};
          end
        end
        default: ;
      endcase
    end
    return hit;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  function automatic logic [7:0] wrong_digit(input logic [3:0] n);
    logic [7:0] c;
    if ($urandom_range(0, 1)) return hex_char(n ^ 4'($urandom_range(1, 15)));
    c = 8'($urandom);
    while (nib_val(c) >= 0) c = 8'($urandom);
    return c;
  endfunction

  // keeps framing characters out of content
  function automatic logic [7:0] safe_char(input logic [7:0] c,
                                           input bit keep_comma);
    if (c == nsf_pkg::CH_DOLLAR || c == nsf_pkg::CH_STAR ||
        (c == nsf_pkg::CH_COMMA && !keep_comma)) return c ^ 8'h01;
    return c;
  endfunction

  function automatic logic [7:0] rand_text(input bit keep_comma);
    logic [7:0] c;
    c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
    return safe_char(c, keep_comma);
  endfunction

  task automatic add_byte(input logic [7:0] ch, input check_e mode,
                          input nsf_pkg::result_t beat);
    stim_bytes.push_back(ch);
    stim_mode.push_back(mode);
    stim_beat.push_back(beat);
  endtask

  task automatic gen_sentence();
    int         tsel;
    int         plen;
    int         brk;
    logic [7:0] c;
    logic [7:0] sum;
    sum = 8'h00;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        add_byte(safe_char(8'($urandom), 1'b1), CHK_MODEL, NO_BEAT);
      end
    end
    add_byte(nsf_pkg::CH_DOLLAR, CHK_MODEL, NO_BEAT);
    tsel = $urandom_range(0, 19);
    if (tsel == 18) begin
      repeat ($urandom_range(0, 4)) add_byte(rand_text(1'b0), CHK_MODEL, NO_BEAT);
      add_byte(nsf_pkg::CH_COMMA, CHK_MODEL, NO_BEAT);
      return;
    end
    if (tsel == 19) begin
      repeat (nsf_pkg::TYPE_LEN + 1) add_byte(rand_text(1'b0), CHK_MODEL, NO_BEAT);
      return;
    end
    for (int i = 0; i < nsf_pkg::TYPE_LEN; i++) begin
      if (tsel < 16) begin
        c = nsf_pkg::KNOWN_TYPES[tsel % nsf_pkg::NUM_TYPES][8*(nsf_pkg::TYPE_LEN-1-i) +: 8];
      end else begin
        c = rand_text(1'b0);
      end
      sum ^= c;
      add_byte(c, CHK_MODEL, NO_BEAT);
    end
    sum ^= nsf_pkg::CH_COMMA;
    add_byte(nsf_pkg::CH_COMMA, CHK_MODEL, NO_BEAT);
    if ($urandom_range(0, 14) == 0) begin
      case ($urandom_range(0, 2))
        0: plen = nsf_pkg::PAYLOAD_MAX;
        1: plen = nsf_pkg::PAYLOAD_MAX + $urandom_range(1, 4);
        default: plen = $urandom_range(50, nsf_pkg::PAYLOAD_MAX - 1);
      endcase
    end else begin
      plen = $urandom_range(0, 20);
    end
    for (int i = 0; i < plen; i++) begin
      c = rand_text(1'b1);
      sum ^= c;
      add_byte(c, CHK_MODEL, NO_BEAT);
    end
    if (plen > nsf_pkg::PAYLOAD_MAX) return;
    brk = $urandom_range(0, 11);
    if (brk == 0) return;
    add_byte(nsf_pkg::CH_STAR, CHK_MODEL, NO_BEAT);
    add_byte(brk == 1 ? wrong_digit(sum[7:4]) : hex_char(sum[7:4]), CHK_MODEL, NO_BEAT);
    add_byte(brk == 2 ? wrong_digit(sum[3:0]) : hex_char(sum[3:0]), CHK_MODEL, NO_BEAT);
    c = 8'($urandom);
    add_byte(brk == 3 ? (c == nsf_pkg::CH_CR ? nsf_pkg::CH_LF : c) : nsf_pkg::CH_CR,
             CHK_MODEL, NO_BEAT);
    c = 8'($urandom);
    add_byte(brk == 4 ? (c == nsf_pkg::CH_LF ? nsf_pkg::CH_CR : c) : nsf_pkg::CH_LF,
             CHK_MODEL, NO_BEAT);
  endtask

  // receiver: stretches of a rotating stall pattern, some fully open
  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_left <= $urandom_range(20, 200);
      rdy_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end else begin
      rdy_left <= rdy_left - 1;
      rdy_pat <= {rdy_pat[14:0], rdy_pat[15]};
    end
    out_if.ready <= rdy_pat[15];
  end

  // predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      next_hit = frame_char(in_if.rx_byte, next_beat);
      if (stim_mode[n_accepted] == CHK_MODEL && next_hit) pending_beats.push_back(next_beat);
      if (stim_mode[n_accepted] == CHK_BEAT) pending_beats.push_back(stim_beat[n_accepted]);
      n_accepted++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_beat.result_kind = nsf_pkg::kind_e'(out_if.result_kind);
      got_beat.payload_byte = out_if.payload_byte;
      got_beat.sentence_type = out_if.sentence_type;
      got_beat.payload_length = out_if.payload_length;
      case (got_beat.result_kind)
        nsf_pkg::KIND_PAYLOAD: n_payload++;
        nsf_pkg::KIND_END: n_closed++;
        default: n_aborted++;
      endcase
      if (pending_beats.size() == 0) begin
        if (n_errors < 10) begin
          $display("%0t: unexpected beat kind %0d byte %02h type %0d len %0d",
                   $realtime, got_beat.result_kind, got_beat.payload_byte,
                   got_beat.sentence_type, got_beat.payload_length);
        end
        n_errors++;
      end else begin
        want_beat = pending_beats.pop_front();
        if (got_beat.result_kind !== want_beat.result_kind ||
            got_beat.payload_byte !== want_beat.payload_byte ||
            got_beat.sentence_type !== want_beat.sentence_type ||
            got_beat.payload_length !== want_beat.payload_length) begin
          if (n_errors < 10) begin
            $display("%0t: expected kind %0d byte %02h type %0d len %0d,",
                     $realtime, want_beat.result_kind, want_beat.payload_byte,
                     want_beat.sentence_type, want_beat.payload_length);
            $display("    got kind %0d byte %02h type %0d len %0d",
                     got_beat.result_kind, got_beat.payload_byte,
                     got_beat.sentence_type, got_beat.payload_length);
          end
          n_errors++;
        end
      end
    end
  end

  initial begin
    int idx;
    int burst;
    int gap;
    in_if.valid <= 1'b0;
    in_if.rx_byte <= 8'h00;
    foreach (dir_tab[i]) add_byte(dir_tab[i].ch, dir_tab[i].mode, dir_tab[i].beat);
    while (stim_bytes.size() < NUM_STIM) gen_sentence();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idx = 0;
    while (idx < stim_bytes.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      while (burst > 0 && idx < stim_bytes.size()) begin
        in_if.valid <= 1'b1;
        in_if.rx_byte <= stim_bytes[idx];
        @(posedge clk_i);
        while (!in_if.ready) @(posedge clk_i);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d bytes sent (%0d directed), %0d payload beats, %0d sentences closed,",
             n_accepted, NUM_DIR, n_payload, n_closed);
    $display("%0d aborted, %0d mismatches", n_aborted, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/nsf_pkg.sv
rtl/nsf_in_if.sv
rtl/nsf_out_if.sv
rtl/nsf_in_stage.sv
rtl/nsf_core.sv
rtl/nsf_out_stage.sv
rtl/nmea_sentence_framer.sv
dv/tb_nmea_sentence_framer.sv
